@@ rtl/core/mcr_pkg.sv @@
// Package for the mailbox command requester.
// Holds result kinds, status codes, register defaults and the shared structs.
// No dependencies.
package mcr_pkg;

	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [7:0]  LEN_MAX        = 8'hFC;
	localparam logic [23:0] ELAPSED_MAX    = 24'hFFFFFF;
	localparam logic [23:0] TIMEOUT_RESET  = 24'd10_000_000;
	localparam logic [15:0] POLL_MIN_RESET = 16'd10;
	localparam logic [19:0] POLL_MAX_RESET = 20'd100_000;

	// register indexes, word addressed
	localparam logic [1:0] REG_ENABLED  = 2'd0;
	localparam logic [1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_POLL_MIN = 2'd2;
	localparam logic [1:0] REG_POLL_MAX = 2'd3;

	typedef enum logic [1:0] {
		KIND_POSTED = 2'd0,
		KIND_WAIT   = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_NOTREADY = 4'd1,
		ST_INVAL    = 4'd2,
		ST_TIMEOUT  = 4'd3,
		ST_PROTO    = 4'd4,
		ST_PERM     = 4'd5,
		ST_NOENT    = 4'd6,
		ST_IO       = 4'd7,
		ST_AGAIN    = 4'd8,
		ST_NOMEM    = 4'd9,
		ST_BUSY     = 4'd10,
		ST_NOSYS    = 4'd11,
		ST_NOTSUP   = 4'd12
	} status_t;

	typedef struct packed {
		logic        enabled;
		logic [23:0] timeout_limit_us;
		logic [15:0] poll_min_us;
		logic [19:0] poll_max_us;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  seq_counter;
		logic        first_epoch;
		logic        busy;
		logic [7:0]  held_capacity;
		logic [19:0] next_wait;
		logic [23:0] elapsed_total;
	} state_t;

	typedef struct packed {
		logic        req_type;
		logic [6:0]  cmd_code;
		logic [7:0]  req_len;
		logic [7:0]  resp_capacity;
		logic [31:0] mbox_header;
		logic [31:0] mbox_first_word;
	} item_t;

	typedef struct packed {
		kind_t       out_kind;
		logic [31:0] req_header;
		logic [19:0] wait_us;
		status_t     status;
		logic [7:0]  used_len;
	} result_t;

	// mailbox error code to status
	function automatic status_t map_error(input logic [31:0] code);
		status_t st;
		unique case (code)
			32'd0:   st = ST_OK;
			32'd1:   st = ST_PERM;
			32'd2:   st = ST_NOENT;
			32'd5:   st = ST_IO;
			32'd11:  st = ST_AGAIN;
			32'd12:  st = ST_NOMEM;
			32'd16:  st = ST_BUSY;
			32'd22:  st = ST_INVAL;
			32'd38:  st = ST_NOSYS;
			32'd62:  st = ST_TIMEOUT;
			32'd95:  st = ST_NOTSUP;
			default: st = ST_IO;
		endcase
		return st;
	endfunction

endpackage

@@ rtl/core/mailbox_command_requester.sv @@
// Top level of the mailbox command requester.
// Input register, exchange state and result register; uses mcr_pkg,
// mcr_cfg_regs and mcr_step.
//
// The block runs one mailbox command exchange at a time. An issue word
// (s_tuser = 0) is checked against the enable register and the length rules
// and, when it passes, yields a request header word (m_tuser = posted) and
// marks the exchange busy. Each header word observed by a poll (s_tuser = 1)
// then either finishes the exchange (m_tuser = done, with a status and the
// used response length) or returns a backoff wait (m_tuser = wait): waits
// start at poll_min_us, double per poll up to poll_max_us, and the exchange
// times out once the summed waits reach timeout_limit_us. A polled header
// while no exchange is pending yields no word. Rejected issues answer done
// with notready, inval or busy and leave the sequence number alone. Rate:
// one word per clock cycle while m_tready holds. A word's result passes the
// input register, then the result register, and is offered on m_tvalid
// from there; the exchange state is updated as the result register loads.
// While a result waits on m_tready the input register still takes one
// word, then s_tready drops until the result leaves. The user must write
// the registers over the APB-style port only while no word is in flight;
// the block itself does not enforce this.
module mailbox_command_requester (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mcr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [mcr_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [mcr_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	// input words
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [6:0] cmd_code, [14:7] req_len, [22:15] resp_capacity,
	// [54:23] mbox_header, [86:55] mbox_first_word, [87] zero
	input  logic [87:0]                    s_tdata,
	// [0] req_type
	input  logic                           s_tuser,
	// result words
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] req_header, [51:32] wait_us, [55:52] status, [63:56] used_len
	output logic [63:0]                    m_tdata,
	// [1:0] out_kind
	output logic [1:0]                     m_tuser
);
	import mcr_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	state_t  state_q;
	state_t  state_nxt;
	result_t res;
	logic    res_valid;
	logic    adv;

	mcr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mcr_step u_step (
		.item      (item_s1),
		.cfg       (cfg),
		.state     (state_q),
		.state_nxt (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// Advance the held word whenever the result register is empty or drains
	// this cycle; the exchange state moves only on that edge.
	assign adv      = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Hold the payload of the input word; no reset needed.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type        <= s_tuser;
			item_s1.cmd_code        <= s_tdata[6:0];
			item_s1.req_len         <= s_tdata[14:7];
			item_s1.resp_capacity   <= s_tdata[22:15];
			item_s1.mbox_header     <= s_tdata[54:23];
			item_s1.mbox_first_word <= s_tdata[86:55];
		end
	end

	// Exchange state: sequence, epoch flag, busy flag and backoff tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.seq_counter   <= '0;
			state_q.first_epoch   <= 1'b1;
			state_q.busy          <= 1'b0;
			state_q.held_capacity <= '0;
			state_q.next_wait     <= {4'd0, POLL_MIN_RESET};
			state_q.elapsed_total <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register valid: load on a produced result, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res_valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.used_len, res_s2.status, res_s2.wait_us, res_s2.req_header};
	assign m_tuser  = res_s2.out_kind;

endmodule

@@ rtl/core/mcr_cfg_regs.sv @@
// Configuration register file of the mailbox command requester.
// APB-style write and read access; depends on mcr_pkg.
module mcr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mcr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [mcr_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [mcr_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	output mcr_pkg::cfg_t                  cfg
);
	import mcr_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled          <= 1'b0;
			cfg_q.timeout_limit_us <= TIMEOUT_RESET;
			cfg_q.poll_min_us      <= POLL_MIN_RESET;
			cfg_q.poll_max_us      <= POLL_MAX_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENABLED:  cfg_q.enabled          <= pwdata[0];
				REG_TIMEOUT:  cfg_q.timeout_limit_us <= pwdata[23:0];
				REG_POLL_MIN: cfg_q.poll_min_us      <= pwdata[15:0];
				REG_POLL_MAX: cfg_q.poll_max_us      <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ENABLED:  prdata = {31'd0, cfg_q.enabled};
			REG_TIMEOUT:  prdata = {8'd0, cfg_q.timeout_limit_us};
			REG_POLL_MIN: prdata = {16'd0, cfg_q.poll_min_us};
			REG_POLL_MAX: prdata = {12'd0, cfg_q.poll_max_us};
			default:      prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/mcr_step.sv @@
// Per-word decision logic of the mailbox command requester.
// Combinational: item, registers and state in; result and next state out.
// Depends on mcr_pkg.
module mcr_step (
	input  mcr_pkg::item_t   item,
	input  mcr_pkg::cfg_t    cfg,
	input  mcr_pkg::state_t  state,
	output mcr_pkg::state_t  state_nxt,
	output logic             res_valid,
	output mcr_pkg::result_t res
);
	import mcr_pkg::*;

	logic [7:0]  rlen;
	logic [3:0]  rseq;
	logic        resp_bit;
	logic        err_bit;
	logic [24:0] sum;
	logic [20:0] dbl;
	logic        bad_len;

	assign rlen     = item.mbox_header[15:8];
	assign rseq     = item.mbox_header[19:16];
	assign resp_bit = item.mbox_header[23];
	assign err_bit  = item.mbox_header[22];
	assign sum      = {1'b0, state.elapsed_total} + {5'd0, state.next_wait};
	assign dbl      = {state.next_wait, 1'b0};
	assign bad_len  = (item.req_len > LEN_MAX) || (item.resp_capacity > LEN_MAX)
		|| (item.req_len[1:0] != 2'd0);

	always_comb begin
		state_nxt      = state;
		res_valid      = 1'b1;
		res.out_kind   = KIND_DONE;
		res.req_header = '0;
		res.wait_us    = '0;
		res.status     = ST_OK;
		res.used_len   = '0;
		if (!item.req_type) begin
			priority if (!cfg.enabled) begin
				res.status = ST_NOTREADY;
			end else if (bad_len) begin
				res.status = ST_INVAL;
			end else if (state.busy) begin
				res.status = ST_BUSY;
			end else begin
				res.out_kind            = KIND_POSTED;
				res.req_header          = {10'd0, ~state.first_epoch, 1'b0,
					state.seq_counter, item.req_len, 1'b0, item.cmd_code};
				state_nxt.busy          = 1'b1;
				state_nxt.held_capacity = item.resp_capacity;
				state_nxt.next_wait     = {4'd0, cfg.poll_min_us};
				state_nxt.elapsed_total = '0;
			end
		end else if (!state.busy) begin
			// header with nothing pending: drop it
			res_valid = 1'b0;
		end else if (resp_bit || (state.elapsed_total >= cfg.timeout_limit_us)) begin
			state_nxt.seq_counter = state.seq_counter + 4'd1;
			state_nxt.first_epoch = 1'b0;
			state_nxt.busy        = 1'b0;
			priority if (!resp_bit) begin
				res.status = ST_TIMEOUT;
			end else if (rseq != state.seq_counter) begin
				res.status = ST_PROTO;
			end else if (err_bit) begin
				// short error reply carries no code: counts as success
				res.status = map_error((rlen >= 8'd4) ? item.mbox_first_word : 32'd0);
			end else begin
				res.used_len = (rlen < state.held_capacity) ? rlen : state.held_capacity;
			end
		end else begin
			res.out_kind            = KIND_WAIT;
			res.wait_us             = state.next_wait;
			state_nxt.elapsed_total = sum[24] ? ELAPSED_MAX : sum[23:0];
			state_nxt.next_wait     = (dbl > {1'b0, cfg.poll_max_us})
				? cfg.poll_max_us : dbl[19:0];
		end
	end

endmodule

@@ tb/mailbox_command_requester_test.sv @@
// Self-checking testbench for mailbox_command_requester.
// Drives issue and poll words over the stream ports, rewrites the registers over APB
// between phases, and checks each result word against a cycle-free model of the exchange.
`timescale 1ns / 1ps

module mailbox_command_requester_test;
	import mcr_pkg::*;

	// mailbox error codes carried in the first response word
	localparam logic [31:0] ERR_NONE     = 32'd0;
	localparam logic [31:0] ERR_PERM     = 32'd1;
	localparam logic [31:0] ERR_NOENT    = 32'd2;
	localparam logic [31:0] ERR_IO       = 32'd5;
	localparam logic [31:0] ERR_AGAIN    = 32'd11;
	localparam logic [31:0] ERR_NOMEM    = 32'd12;
	localparam logic [31:0] ERR_BUSY     = 32'd16;
	localparam logic [31:0] ERR_INVAL    = 32'd22;
	localparam logic [31:0] ERR_NOSYS    = 32'd38;
	localparam logic [31:0] ERR_TIMEDOUT = 32'd62;
	localparam logic [31:0] ERR_NOTSUP   = 32'd95;

	localparam int RESP_BIT  = 23;
	localparam int ERROR_BIT = 22;
	localparam int RUN_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	// Tracks the exchange state and the result words still owed by the block.
	class exchange_tracker;
		logic        enabled;
		logic [23:0] timeout_limit;
		logic [15:0] poll_min;
		logic [19:0] poll_max;
		logic [3:0]  seq_no;
		logic        first_epoch;
		logic        busy;
		logic [7:0]  held_cap;
		logic [19:0] next_wait;
		logic [23:0] elapsed;
		result_t     due_results[$];
		int          errors;
		int          n_posted;
		int          n_waits;
		int          n_done;
		int          n_timeouts;
		int          n_proto;
		int          n_saturated;

		function new();
			enabled       = 1'b0;
			timeout_limit = TIMEOUT_RESET;
			poll_min      = POLL_MIN_RESET;
			poll_max      = POLL_MAX_RESET;
			seq_no        = '0;
			first_epoch   = 1'b1;
			busy          = 1'b0;
			held_cap      = '0;
			next_wait     = 20'(POLL_MIN_RESET);
			elapsed       = '0;
			errors        = 0;
			n_posted      = 0;
			n_waits       = 0;
			n_done        = 0;
			n_timeouts    = 0;
			n_proto       = 0;
			n_saturated   = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_ENABLED:  enabled = val[0];
				REG_TIMEOUT:  timeout_limit = val[23:0];
				REG_POLL_MIN: poll_min = val[15:0];
				REG_POLL_MAX: poll_max = val[19:0];
				default: ;
			endcase
		endfunction

		function status_t status_of(logic [31:0] code);
			case (code)
				ERR_NONE:     return ST_OK;
				ERR_PERM:     return ST_PERM;
				ERR_NOENT:    return ST_NOENT;
				ERR_IO:       return ST_IO;
				ERR_AGAIN:    return ST_AGAIN;
				ERR_NOMEM:    return ST_NOMEM;
				ERR_BUSY:     return ST_BUSY;
				ERR_INVAL:    return ST_INVAL;
				ERR_NOSYS:    return ST_NOSYS;
				ERR_TIMEDOUT: return ST_TIMEOUT;
				ERR_NOTSUP:   return ST_NOTSUP;
				default:      return ST_IO;
			endcase
		endfunction

		function void close_exchange();
			seq_no      = seq_no + 4'd1;
			first_epoch = 1'b0;
			busy        = 1'b0;
		endfunction

		// Advance the model by one accepted word; returns 1 when a result is owed.
		function bit take_word(item_t w);
			result_t     r;
			logic [31:0] hdr;
			logic [7:0]  rlen;
			logic [31:0] sum;
			logic [31:0] dbl;
			r.out_kind   = KIND_DONE;
			r.req_header = '0;
			r.wait_us    = '0;
			r.status     = ST_OK;
			r.used_len   = '0;
			hdr  = w.mbox_header;
			rlen = hdr[15:8];
			if (w.req_type == 1'b0) begin
				if (!enabled)
					r.status = ST_NOTREADY;
				else if (w.req_len > LEN_MAX || w.resp_capacity > LEN_MAX ||
						w.req_len[1:0] != 2'b00)
					r.status = ST_INVAL;
				else if (busy)
					r.status = ST_BUSY;
				else begin
					r.out_kind   = KIND_POSTED;
					r.req_header = {10'd0, ~first_epoch, 1'b0, seq_no, w.req_len,
						1'b0, w.cmd_code};
					busy      = 1'b1;
					held_cap  = w.resp_capacity;
					next_wait = 20'(poll_min);
					elapsed   = '0;
				end
			end else if (!busy) begin
				return 1'b0;
			end else if (hdr[RESP_BIT]) begin
				if (hdr[19:16] != seq_no) begin
					r.status = ST_PROTO;
					n_proto++;
				end else if (hdr[ERROR_BIT])
					r.status = status_of(rlen >= 8'd4 ? w.mbox_first_word : ERR_NONE);
				else
					r.used_len = rlen < held_cap ? rlen : held_cap;
				close_exchange();
			end else if (elapsed >= timeout_limit) begin
				r.status = ST_TIMEOUT;
				n_timeouts++;
				close_exchange();
			end else begin
				r.out_kind = KIND_WAIT;
				r.wait_us  = next_wait;
				sum = 32'(elapsed) + 32'(next_wait);
				dbl = 32'(next_wait) * 32'd2;
				if (sum > 32'(ELAPSED_MAX)) begin
					elapsed = ELAPSED_MAX;
					n_saturated++;
				end else
					elapsed = sum[23:0];
				next_wait = dbl > 32'(poll_max) ? poll_max : dbl[19:0];
			end
			case (r.out_kind)
				KIND_POSTED: n_posted++;
				KIND_WAIT:   n_waits++;
				default:     n_done++;
			endcase
			due_results.push_back(r);
			return 1'b1;
		endfunction

		function void match(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [1:0] kind, logic [63:0] data);
			result_t want;
			if (due_results.size() == 0) begin
				$error("result word with nothing outstanding: kind %0h data %0h", kind, data);
				errors++;
				return;
			end
			want = due_results.pop_front();
			match("out_kind", 32'(want.out_kind), 32'(kind));
			match("req_header", want.req_header, data[31:0]);
			match("wait_us", 32'(want.wait_us), 32'(data[51:32]));
			match("status", 32'(want.status), 32'(data[55:52]));
			match("used_len", 32'(want.used_len), 32'(data[63:56]));
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	// [6:0] cmd_code, [14:7] req_len, [22:15] resp_capacity,
	// [54:23] mbox_header, [86:55] mbox_first_word, [87] zero
	logic [87:0]           s_tdata;
	// [0] req_type
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [31:0] req_header, [51:32] wait_us, [55:52] status, [63:56] used_len
	logic [63:0]           m_tdata;
	// [1:0] out_kind
	logic [1:0]            m_tuser;

	exchange_tracker tracker = new();

	logic [31:0] mbox_errs [11] = '{ERR_NONE, ERR_PERM, ERR_NOENT, ERR_IO, ERR_AGAIN,
		ERR_NOMEM, ERR_BUSY, ERR_INVAL, ERR_NOSYS, ERR_TIMEDOUT, ERR_NOTSUP};

	int cycle_count = 0;
	int words_with_results = 0;
	int words_offered = 0;
	int settings_applied = 0;
	int burst_left = 0;
	bit steady = 1'b0;
	// the sender bumps hold_asks; the receiver notices and counts out the hold itself
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int rx_cycle = 0;
	int rx_mode = 0;

	mailbox_command_requester uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: check every accepted word, then pick m_tready for the next edge.
	// Stall modes are drawn at random from: always ready, mostly ready, mostly
	// stalled, and a fixed 4-of-7 pattern. A requested hold overrides them all.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			tracker.check_result(m_tuser, m_tdata);
		rx_cycle++;
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_cycle % 80 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((rx_cycle % 7) < 4);
			endcase
		end
	end

	// Hard stop: a hung handshake or a lost result ends here.
	initial begin : watchdog
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Offer one word and hold it until the block takes it. Outside steady mode
	// the sender works in bursts with idle gaps between them.
	task automatic offer(item_t w);
		int gap;
		if (!steady) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tuser  <= w.req_type;
		s_tdata  <= {1'b0, w.mbox_first_word, w.mbox_header, w.resp_capacity, w.req_len,
			w.cmd_code};
		do @(posedge clk); while (!s_tready);
		words_offered++;
		if (tracker.take_word(w))
			words_with_results++;
	endtask

	// Drop valid and wait until every owed result is back, then leave time
	// for a header word that the block may still be dropping.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.pending() > 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic apply_setting(logic en, logic [23:0] tmo, logic [15:0] pmin,
			logic [19:0] pmax);
		settle();
		write_reg(REG_ENABLED, 32'(en));
		write_reg(REG_TIMEOUT, 32'(tmo));
		write_reg(REG_POLL_MIN, 32'(pmin));
		write_reg(REG_POLL_MAX, 32'(pmax));
		settings_applied++;
	endtask

	// issue word; the header fields are don't-care here, so fill them with noise
	function automatic item_t issue_word(logic [6:0] code, logic [7:0] len, logic [7:0] cap);
		item_t w;
		w.req_type        = 1'b0;
		w.cmd_code        = code;
		w.req_len         = len;
		w.resp_capacity   = cap;
		w.mbox_header     = $urandom;
		w.mbox_first_word = $urandom;
		return w;
	endfunction

	function automatic item_t header_word(logic [31:0] hdr, logic [31:0] first);
		item_t w;
		w.req_type        = 1'b1;
		w.cmd_code        = 7'($urandom);
		w.req_len         = 8'($urandom);
		w.resp_capacity   = 8'($urandom);
		w.mbox_header     = hdr;
		w.mbox_first_word = first;
		return w;
	endfunction

	function automatic logic [31:0] resp_header(bit err, logic [3:0] seq, logic [7:0] len);
		logic [31:0] hdr;
		hdr            = $urandom;
		hdr[RESP_BIT]  = 1'b1;
		hdr[ERROR_BIT] = err;
		hdr[19:16]     = seq;
		hdr[15:8]      = len;
		return hdr;
	endfunction

	function automatic logic [31:0] busy_header();
		logic [31:0] hdr;
		hdr           = $urandom;
		hdr[RESP_BIT] = 1'b0;
		return hdr;
	endfunction

	// Random traffic: mostly whole exchanges (issue, a few polls, a response),
	// some rejected issues and some raw noise. Runs until budget words have gone in.
	task automatic play(int budget, int max_polls);
		int          start;
		int          pick;
		int          polls;
		logic [7:0]  len;
		logic [7:0]  cap;
		logic [7:0]  rlen;
		logic [3:0]  seq;
		logic [31:0] first;
		bit          err;
		item_t       w;
		start = words_offered;
		while (words_offered - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				w = header_word($urandom, $urandom);
				w.req_type = 1'($urandom);
				offer(w);
			end else if (pick < 14) begin
				len = 8'(4 * $urandom_range(0, 63));
				cap = 8'($urandom_range(0, 252));
				case ($urandom_range(0, 2))
					0: len = 8'($urandom_range(253, 255));
					1: cap = 8'($urandom_range(253, 255));
					default: len = len | 8'($urandom_range(1, 3));
				endcase
				offer(issue_word(7'($urandom), len, cap));
			end else begin
				offer(issue_word(7'($urandom), 8'(4 * $urandom_range(0, 63)),
					8'($urandom_range(0, 252))));
				if ($urandom_range(0, 9) == 0)
					offer(issue_word(7'($urandom), 8'(4 * $urandom_range(0, 63)),
						8'($urandom)));
				polls = $urandom_range(0, max_polls);
				repeat (polls) offer(header_word(busy_header(), $urandom));
				seq  = ($urandom_range(0, 9) != 0) ? tracker.seq_no : 4'($urandom);
				err  = ($urandom_range(0, 2) == 0);
				rlen = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
				first = (err && $urandom_range(0, 3) != 0) ?
					mbox_errs[$urandom_range(0, 10)] : $urandom;
				offer(header_word(resp_header(err, seq, rlen), first));
			end
		end
	endtask

	initial begin : stimulus
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		arst_n   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the transport is off: an issue is refused, a header dropped.
		offer(issue_word(7'd5, 8'd8, 8'd16));
		offer(header_word(resp_header(1'b0, 4'd0, 8'd4), ERR_NONE));

		apply_setting(1'b1, 24'd200, 16'd10, 20'd100000);
		// first exchange: zero code and lengths, header without the epoch bit
		offer(issue_word(7'd0, 8'd0, 8'd0));
		offer(issue_word(7'd127, 8'd252, 8'd252));
		offer(header_word(32'h0000_0000, 32'h0000_0000));
		offer(header_word(32'hFF7F_FFFF, 32'hFFFF_FFFF));
		offer(header_word(resp_header(1'b0, tracker.seq_no, 8'd200), ERR_NONE));
		// widest lengths, then a response with the wrong sequence number
		offer(issue_word(7'd127, 8'd252, 8'd252));
		offer(header_word(resp_header(1'b0, tracker.seq_no ^ 4'd1, 8'd16), ERR_NONE));
		// every way an issue fails the length rules
		offer(issue_word(7'd1, 8'd253, 8'd0));
		offer(issue_word(7'd1, 8'd4, 8'd253));
		offer(issue_word(7'd1, 8'd6, 8'd8));
		offer(issue_word(7'd1, 8'd255, 8'd255));
		// error reply too short to carry a code reads as success
		offer(issue_word(7'd2, 8'd8, 8'd100));
		offer(header_word(resp_header(1'b1, tracker.seq_no, 8'd3), ERR_IO));
		offer(issue_word(7'd3, 8'd12, 8'd10));
		offer(header_word(resp_header(1'b1, tracker.seq_no, 8'd4), ERR_TIMEDOUT));
		// response longer than the caller can take is cut to the capacity
		offer(issue_word(7'd4, 8'd16, 8'd10));
		offer(header_word(resp_header(1'b0, tracker.seq_no, 8'd255), ERR_NONE));
		// back off 10, 20, 40, 80, 160 and then time out
		offer(issue_word(7'd5, 8'd4, 8'd7));
		repeat (6) offer(header_word(busy_header(), $urandom));

		// Hold the result side off while words keep coming, so the block backs up
		// and drops s_tready; then carry on with normal bursts.
		hold_asks++;
		steady = 1'b1;
		play(40, 4);
		steady = 1'b0;
		play(260, 8);

		// top of the poll_min range, near the top of the others; long exchanges reach the elapsed ceiling
		apply_setting(1'b1, 24'd16000000, 16'd65535, 20'd1000000);
		play(250, 26);
		// zero timeout, lowest nonzero waits: the first unanswered poll times out
		apply_setting(1'b1, 24'd0, 16'd1, 20'd1);
		play(200, 4);
		// zero first wait: waits stay zero and never time out
		apply_setting(1'b1, 24'd50, 16'd0, 20'd5);
		play(200, 6);
		// first wait above the cap goes out uncapped, later ones are capped
		apply_setting(1'b1, 24'd1000, 16'd300, 20'd100);
		play(200, 12);
		// transport off again: every issue is refused
		apply_setting(1'b0, 24'd500, 16'd20, 20'd400);
		play(100, 3);
		repeat (3) begin
			apply_setting(1'b1, 24'($urandom_range(0, 3000)), 16'($urandom_range(0, 400)),
				20'($urandom_range(1, 5000)));
			play(200, 10);
		end

		settle();
		$display("Covered %0d words with results under %0d register settings.",
			words_with_results, settings_applied);
		$display("Results: %0d posted, %0d waits, %0d finished (%0d timeouts, %0d proto, %0d saturated).",
			tracker.n_posted, tracker.n_waits, tracker.n_done, tracker.n_timeouts,
			tracker.n_proto, tracker.n_saturated);
		if (tracker.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
